// ===== rtl/core/tlvdc_pkg.sv =====
// Shared constants, codes and control types of the TLV duplicate id checker.
`default_nettype none
package tlvdc_pkg;

  // Table size and the widths that follow from it.
  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ID_W        = 62;
  localparam int OUT_CNT_W   = 6;

  // Failure codes as reported in error_kind.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_DUP   = 2'd3
  } err_t;

  // Parser phase within one record.
  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_run;
    logic record_id;
    logic set_fail;
    err_t fail_code;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rec_done;
    logic table_full;
    logic scan_hit;
    logic scan_end;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/tlvdc_ifs.sv =====
// Valid/ready channel interfaces for the input byte words and the result words.
`default_nettype none
interface tlvdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_present,
                  output last_byte, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input last_byte, output ready);
endinterface

interface tlvdc_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] error_kind;
  logic [5:0] param_count;

  modport source (output valid, output accepted, output error_kind,
                  output param_count, input ready);
  modport sink (input valid, input accepted, input error_kind,
                input param_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tlvdc_dpath.sv =====
// Datapath: varint parser, id table memory, table scan and result register.
`default_nettype none
module tlvdc_dpath (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [7:0]            in_data_byte,
  input  wire                   in_byte_present,
  input  wire                   out_ready,
  input  tlvdc_pkg::cmd_t       cmd,
  output tlvdc_pkg::status_t    status,
  output logic                  out_valid,
  output logic                  out_accepted,
  output logic [1:0]            out_error_kind,
  output logic [5:0]            out_param_count
);
  import tlvdc_pkg::*;

  // Parser and block state.
  phase_t             phase_r, phase_nxt;
  logic [2:0]         vleft_r, vleft_nxt;
  logic [ID_W-1:0]    accum_r, accum_nxt;
  logic [ID_W-1:0]    cur_id_r, cur_id_nxt;
  logic [ID_W-1:0]    vbytes_r, vbytes_nxt;
  err_t               fail_r;
  logic [CNT_W-1:0]   count_r;
  logic               rec_done_raw;
  logic               take;

  // Table memory and scan state.
  logic [ID_W-1:0]    id_mem [TABLE_DEPTH];
  logic [ID_W-1:0]    rd_data_r;
  logic               rd_vld_r;
  logic [CNT_W-1:0]   scan_idx_r;

  // Result register.
  logic               out_valid_r;
  logic               out_acc_r;
  err_t               out_err_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  err_t               code;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
  logic [OUT_CNT_W-1:0] cnt_sat;

  // A byte is parsed only while the block has not failed.
  assign take = cmd.accept && in_byte_present && (fail_r == ERR_NONE);

  // Next parser state for the incoming byte.
  always_comb begin
    phase_nxt    = phase_r;
    vleft_nxt    = vleft_r;
    accum_nxt    = accum_r;
    cur_id_nxt   = cur_id_r;
    vbytes_nxt   = vbytes_r;
    rec_done_raw = 1'b0;
    if (phase_r == PH_VALUE) begin
      vbytes_nxt = vbytes_r - ID_W'(1);
      if (vbytes_nxt == '0) begin
        rec_done_raw = 1'b1;
        phase_nxt    = PH_ID;
      end
    end else begin
      if (vleft_r == 3'd0) begin
        // First byte of a varint: the top two bits give its length.
        accum_nxt = {{(ID_W-6){1'b0}}, in_data_byte[5:0]};
        case (in_data_byte[7:6])
          2'd0:    vleft_nxt = 3'd0;
          2'd1:    vleft_nxt = 3'd1;
          2'd2:    vleft_nxt = 3'd3;
          default: vleft_nxt = 3'd7;
        endcase
      end else begin
        accum_nxt = {accum_r[ID_W-9:0], in_data_byte};
        vleft_nxt = vleft_r - 3'd1;
      end
      if (vleft_nxt == 3'd0) begin
        case (phase_r)
          PH_LEN: begin
            vbytes_nxt = accum_nxt;
            if (accum_nxt == '0) begin
              rec_done_raw = 1'b1;
              phase_nxt    = PH_ID;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
          default: begin
            cur_id_nxt = accum_nxt;
            phase_nxt  = PH_LEN;
          end
        endcase
      end
    end
  end

  // Parser, failure and count registers.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      phase_r  <= PH_ID;
      vleft_r  <= '0;
      accum_r  <= '0;
      cur_id_r <= '0;
      vbytes_r <= '0;
      fail_r   <= ERR_NONE;
      count_r  <= '0;
    end else begin
      if (take) begin
        phase_r  <= phase_nxt;
        vleft_r  <= vleft_nxt;
        accum_r  <= accum_nxt;
        cur_id_r <= cur_id_nxt;
        vbytes_r <= vbytes_nxt;
      end
      if (cmd.set_fail) begin
        fail_r <= cmd.fail_code;
      end
      if (cmd.record_id) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.record_id) begin
      id_mem[count_r[IDX_W-1:0]] <= cur_id_r;
    end
    rd_data_r <= id_mem[scan_idx_r[IDX_W-1:0]];
  end

  // Scan walks the recorded entries one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_start) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else if (cmd.scan_run) begin
      if (scan_idx_r < count_r) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
        rd_vld_r   <= 1'b1;
      end else begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  // Final code and saturated count for the result word.
  always_comb begin
    code = fail_r;
    if (fail_r == ERR_NONE && (phase_r != PH_ID || vleft_r != 3'd0)) begin
      code = ERR_TRUNC;
    end
    cnt_ext = {{OUT_CNT_W{1'b0}}, count_r};
    if (cnt_ext > (CNT_W+OUT_CNT_W)'((2 ** OUT_CNT_W) - 1)) begin
      cnt_sat = '1;
    end else begin
      cnt_sat = cnt_ext[OUT_CNT_W-1:0];
    end
  end

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_acc_r <= (code == ERR_NONE);
      out_err_r <= code;
      out_cnt_r <= cnt_sat;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.rec_done   = take && rec_done_raw;
    status.table_full = (count_r >= CNT_W'(TABLE_DEPTH));
    status.scan_hit   = rd_vld_r && (rd_data_r == cur_id_r);
    status.scan_end   = (scan_idx_r >= count_r) && !rd_vld_r;
    status.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_error_kind  = out_err_r;
  assign out_param_count = out_cnt_r;

endmodule
`default_nettype wire

// ===== rtl/core/tlvdc_ctrl.sv =====
// Controller: sequences byte intake, table scan and result delivery.
`default_nettype none
module tlvdc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_last_byte,
  input  tlvdc_pkg::status_t  status,
  output logic                in_ready,
  output tlvdc_pkg::cmd_t     cmd
);
  import tlvdc_pkg::*;

  state_t state_r, state_nxt;
  logic   last_pend_r;

  // State register and the pending end-of-block flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_valid) begin
        last_pend_r <= in_last_byte;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.rec_done && !status.table_full) begin
          state_nxt = ST_SCAN;
        end else if (in_valid && in_last_byte) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_SCAN: begin
        if (status.scan_hit || status.scan_end) begin
          state_nxt = last_pend_r ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.fail_code  = ERR_NONE;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.rec_done) begin
          if (status.table_full) begin
            cmd.set_fail  = 1'b1;
            cmd.fail_code = ERR_FULL;
          end else begin
            cmd.scan_start = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_hit) begin
          cmd.set_fail  = 1'b1;
          cmd.fail_code = ERR_DUP;
        end else if (status.scan_end) begin
          cmd.record_id = 1'b1;
        end
      end
      ST_REPORT: begin
        cmd.load_out = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/tlv_duplicate_id_checker_unit.sv =====
// Top level of the TLV duplicate id checker.
//
// The input channel carries one byte word per handshake: data_byte, a
// byte_present flag and last_byte, which closes a parameter block. The
// result channel gives one word per block (accepted, error_kind,
// param_count) after the word that carries last_byte.
// A byte word is taken whenever the controller is idle. A byte that
// completes a record, unless the table is full, starts a scan of the id
// table through its single memory read port, one entry per cycle; the
// input is held off until the scan ends or finds a duplicate.
// After the last word is taken the controller enters its report state,
// which loads the result into the output register once that register is
// free; when the last word closes a record, the table scan runs first.
// The result sits in an output register. Byte words keep flowing while it
// waits; when the next block ends, its result and the input wait until the
// receiver takes the first.
// Synchronous reset clears the parser, the id count and the channels; the
// table contents are not cleared, since only recorded entries are read.
`default_nettype none
module tlv_duplicate_id_checker_unit (
  input wire          clk,
  input wire          rst_n,
  tlvdc_in_if.sink    in_chan,
  tlvdc_out_if.source out_chan
);
  import tlvdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  tlvdc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_last_byte (in_chan.last_byte),
    .status       (status),
    .in_ready     (in_chan.ready),
    .cmd          (cmd)
  );

  tlvdc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_chan.data_byte),
    .in_byte_present (in_chan.byte_present),
    .out_ready       (out_chan.ready),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_chan.valid),
    .out_accepted    (out_chan.accepted),
    .out_error_kind  (out_chan.error_kind),
    .out_param_count (out_chan.param_count)
  );

endmodule
`default_nettype wire
